### hdl/sliding_window_lane_search_defines.svh
// Assertion macros for the sliding window lane search block.
// Used by the top level only; no other dependencies.
`ifndef SLIDING_WINDOW_LANE_SEARCH_DEFINES_SVH
`define SLIDING_WINDOW_LANE_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset
`define SWLS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("swls assertion failed");
// Next-cycle implication, disabled in reset
`define SWLS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("swls assertion failed");
`else
`define SWLS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SWLS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### hdl/swls_pkg.sv
// Package for the sliding window lane search: item types, constants,
// controller states and the command/status structs. No dependencies.
package swls_pkg;

    // Default geometry
    localparam int IMG_WIDTH_DEF   = 512;
    localparam int IMG_HEIGHT_DEF  = 512;
    localparam int NUM_WINDOWS_DEF = 8;

    // Fixed field widths
    localparam int PIX_VAL_W = 8;
    localparam int WNUM_W    = 3;
    localparam int CENTER_W  = 9;
    localparam int HITS_W    = 16;
    localparam int COLSUM_W  = 17;
    localparam int HW_W      = 10;
    localparam int THR_W     = 19;

    // Register map and reset values
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_HALF_WIDTH = 1'b0;
    localparam logic REG_MIN_PIXELS = 1'b1;
    localparam logic [HW_W-1:0]  HW_RESET  = HW_W'(65);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(400);

    typedef struct packed {
        logic [PIX_VAL_W-1:0] pixel_value;
        logic                 frame_end;
    } in_item_t;

    typedef struct packed {
        logic [WNUM_W-1:0]   window_number;
        logic [CENTER_W-1:0] left_center;
        logic [CENTER_W-1:0] right_center;
        logic [HITS_W-1:0]   left_hits;
        logic [HITS_W-1:0]   right_hits;
        logic                last_window;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_FLUSH,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_TRACKS,
        ST_BOX_INIT,
        ST_BOX,
        ST_BOX_DRAIN,
        ST_RESULT,
        ST_DIV_L,
        ST_DIV_L_RUN,
        ST_DIV_R,
        ST_DIV_R_RUN,
        ST_WIN_NEXT
    } swls_state_t;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic scan_init;
        logic scan_step;
        logic load_tracks;
        logic win_init;
        logic box_init;
        logic box_step;
        logic side_next;
        logic emit;
        logic div_start_l;
        logic div_start_r;
        logic next_win;
    } swls_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic box_empty;
        logic box_last;
        logic side_right;
        logic recenter_l;
        logic recenter_r;
        logic div_done;
        logic win_last;
        logic out_free;
    } swls_status_t;

endpackage

### hdl/swls_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module swls_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and read with old data on collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/swls_ctrl.sv
// Controller FSM of the lane search: sequences clearing, loading, the
// start-column scan, box counting and recentering. Uses swls_pkg.
module swls_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_frame_end,
    input  swls_pkg::swls_status_t status,
    output swls_pkg::swls_cmd_t    cmd,
    output logic                  s_ready
);
    import swls_pkg::*;

    swls_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.idx_last) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && s_frame_end) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                cmd.scan_init = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.idx_last) begin
                    state_next = ST_SCAN_DRAIN;
                end
            end
            ST_SCAN_DRAIN: begin
                state_next = ST_TRACKS;
            end
            ST_TRACKS: begin
                cmd.load_tracks = 1'b1;
                cmd.win_init    = 1'b1;
                state_next      = ST_BOX_INIT;
            end
            ST_BOX_INIT: begin
                cmd.box_init = 1'b1;
                state_next   = status.box_empty ? ST_BOX_DRAIN : ST_BOX;
            end
            ST_BOX: begin
                cmd.box_step = 1'b1;
                if (status.box_last) begin
                    state_next = ST_BOX_DRAIN;
                end
            end
            ST_BOX_DRAIN: begin
                if (!status.side_right) begin
                    cmd.side_next = 1'b1;
                    state_next    = ST_BOX_INIT;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_DIV_L;
                end
            end
            ST_DIV_L: begin
                if (status.recenter_l) begin
                    cmd.div_start_l = 1'b1;
                    state_next      = ST_DIV_L_RUN;
                end else begin
                    state_next = ST_DIV_R;
                end
            end
            ST_DIV_L_RUN: begin
                if (status.div_done) begin
                    state_next = ST_DIV_R;
                end
            end
            ST_DIV_R: begin
                if (status.recenter_r) begin
                    cmd.div_start_r = 1'b1;
                    state_next      = ST_DIV_R_RUN;
                end else begin
                    state_next = ST_WIN_NEXT;
                end
            end
            ST_DIV_R_RUN: begin
                if (status.div_done) begin
                    state_next = ST_WIN_NEXT;
                end
            end
            ST_WIN_NEXT: begin
                if (status.win_last) begin
                    state_next = ST_LOAD;
                end else begin
                    cmd.next_win = 1'b1;
                    state_next   = ST_BOX_INIT;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

### hdl/swls_datapath.sv
// Datapath of the lane search: pixel map and column sum memories, scan,
// box counters, mean divider and result register. Uses swls_pkg, swls_ram.
module swls_datapath #(
    parameter int IMG_WIDTH   = swls_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT  = swls_pkg::IMG_HEIGHT_DEF,
    parameter int NUM_WINDOWS = swls_pkg::NUM_WINDOWS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  swls_pkg::swls_cmd_t         cmd,
    input  swls_pkg::in_item_t          s_item,
    input  logic [swls_pkg::HW_W-1:0]   half_width,
    input  logic [swls_pkg::THR_W-1:0]  min_pixels,
    input  logic                        m_ready,
    output swls_pkg::swls_status_t      status,
    output logic                        m_valid,
    output swls_pkg::out_item_t         m_item
);
    import swls_pkg::*;

    localparam int X_W       = $clog2(IMG_WIDTH);
    localparam int XC_W      = $clog2(IMG_WIDTH + 1);
    localparam int PIX_TOTAL = IMG_WIDTH * IMG_HEIGHT;
    localparam int PIX_W     = $clog2(PIX_TOTAL);
    localparam int WH        = IMG_HEIGHT / NUM_WINDOWS;
    localparam int ROW_W     = $clog2(WH + 1);
    localparam int CNT_W     = $clog2(WH * IMG_WIDTH + 1);
    localparam int SUM_W     = CNT_W + X_W;
    localparam int DCNT_W    = $clog2(SUM_W + 1);
    localparam int WIN_W     = $clog2(NUM_WINDOWS + 1);
    localparam int LIM_W     = ((X_W > HW_W) ? X_W : HW_W) + 2;
    localparam int HALF_START = (IMG_HEIGHT / 2) * IMG_WIDTH;
    localparam int BASE_FIRST = (IMG_HEIGHT - WH) * IMG_WIDTH;
    localparam int BASE_STEP  = WH * IMG_WIDTH;

    // Loading state
    logic [PIX_W-1:0]     pos_reg, pos_next;
    logic [X_W-1:0]       col_reg, col_next;
    logic                 pend_v_reg;
    logic [X_W-1:0]       pend_col_reg;
    logic [PIX_VAL_W-1:0] pend_pix_reg;

    // Scan state
    logic [X_W-1:0]      idx_reg;
    logic                rd_v_reg;
    logic [X_W-1:0]      rd_x_reg;
    logic [X_W-1:0]      best_l_reg, best_r_reg;
    logic [COLSUM_W-1:0] bval_l_reg, bval_r_reg;

    // Window and box state
    logic [X_W-1:0]   track_l_reg, track_r_reg;
    logic [WIN_W-1:0] win_reg;
    logic [PIX_W-1:0] base_reg;
    logic             side_reg;
    logic [XC_W-1:0]  xlo_reg, xhi_reg, x_reg;
    logic [ROW_W-1:0] row_reg;
    logic [PIX_W-1:0] row_addr_reg;
    logic             bv_reg;
    logic [X_W-1:0]   bx_reg;
    logic [CNT_W-1:0] cnt_l_reg, cnt_r_reg;
    logic [SUM_W-1:0] sum_l_reg, sum_r_reg;

    // Divider state
    logic              div_run_reg, div_side_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [CNT_W:0]    div_rem_reg;
    logic [SUM_W-1:0]  div_quo_reg;
    logic [CNT_W-1:0]  div_d_reg;

    // Output register
    logic      m_valid_reg;
    out_item_t m_item_reg;

    // Memory ports
    logic                col_we;
    logic [X_W-1:0]      col_waddr, col_raddr;
    logic [COLSUM_W-1:0] col_wdata, col_rdata;
    logic [PIX_W-1:0]    map_raddr;
    logic                map_rdata;

    // Combinational helpers
    logic [COLSUM_W:0]       col_sum;
    logic [X_W-1:0]          ctr;
    logic signed [LIM_W-1:0] lo_s;
    logic [LIM_W-1:0]        hi_u;
    logic [XC_W-1:0]         xlo_c, xhi_c;
    logic                    x_last, row_last;
    logic [CNT_W:0]          div_trial;
    logic                    div_bit;
    logic [SUM_W-1:0]        quo_new;

    swls_ram #(.WIDTH(1), .DEPTH(PIX_TOTAL)) u_map_ram (
        .aclk  (aclk),
        .we    (cmd.accept),
        .waddr (pos_reg),
        .wdata (s_item.pixel_value != '0),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    swls_ram #(.WIDTH(COLSUM_W), .DEPTH(IMG_WIDTH)) u_col_ram (
        .aclk  (aclk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    // Column sum port muxing: saturating update or zero fill
    always_comb begin
        col_sum   = {1'b0, col_rdata} + (COLSUM_W + 1)'(pend_pix_reg);
        col_we    = pend_v_reg || cmd.clear_step || cmd.scan_step;
        col_waddr = pend_v_reg ? pend_col_reg : idx_reg;
        col_wdata = '0;
        if (pend_v_reg) begin
            col_wdata = col_sum[COLSUM_W] ? '1 : col_sum[COLSUM_W-1:0];
        end
        col_raddr = cmd.accept ? col_reg : idx_reg;
    end

    // Pixel position
    always_comb begin
        pos_next = pos_reg;
        col_next = col_reg;
        if (cmd.accept) begin
            if (s_item.frame_end || pos_reg == PIX_W'(PIX_TOTAL - 1)) begin
                pos_next = '0;
                col_next = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
                col_next = (col_reg == X_W'(IMG_WIDTH - 1)) ? '0 : col_reg + 1'b1;
            end
        end
    end

    // Box limits clipped to the image
    always_comb begin
        ctr   = side_reg ? track_r_reg : track_l_reg;
        lo_s  = $signed(LIM_W'(ctr)) - $signed(LIM_W'(half_width));
        hi_u  = LIM_W'(ctr) + LIM_W'(half_width);
        xlo_c = lo_s[LIM_W-1] ? '0 : XC_W'(lo_s);
        xhi_c = (hi_u > LIM_W'(IMG_WIDTH)) ? XC_W'(IMG_WIDTH) : XC_W'(hi_u);
        x_last    = (x_reg == xhi_reg - 1'b1);
        row_last  = (row_reg == ROW_W'(WH - 1));
        map_raddr = row_addr_reg + PIX_W'(x_reg);
    end

    // Restoring divider step
    always_comb begin
        div_trial = {div_rem_reg[CNT_W-1:0], div_quo_reg[SUM_W-1]};
        div_bit   = (div_trial >= {1'b0, div_d_reg});
        quo_new   = {div_quo_reg[SUM_W-2:0], div_bit};
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            col_reg     <= '0;
            pend_v_reg  <= 1'b0;
            idx_reg     <= '0;
            rd_v_reg    <= 1'b0;
            bv_reg      <= 1'b0;
            div_run_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            track_l_reg <= '0;
            track_r_reg <= '0;
        end else begin
            pos_reg    <= pos_next;
            col_reg    <= col_next;
            pend_v_reg <= cmd.accept && (pos_reg >= PIX_W'(HALF_START));
            if (cmd.scan_init) begin
                idx_reg <= '0;
            end else if (cmd.clear_step || cmd.scan_step) begin
                idx_reg <= (idx_reg == X_W'(IMG_WIDTH - 1)) ? '0 : idx_reg + 1'b1;
            end
            rd_v_reg <= cmd.scan_step;
            bv_reg   <= cmd.box_step;
            if (cmd.load_tracks) begin
                track_l_reg <= best_l_reg;
                track_r_reg <= best_r_reg;
            end
            // Divider run and commit of the new center
            if (cmd.div_start_l || cmd.div_start_r) begin
                div_run_reg <= 1'b1;
            end else if (div_run_reg && div_cnt_reg == DCNT_W'(1)) begin
                div_run_reg <= 1'b0;
                if (div_side_reg) begin
                    track_r_reg <= X_W'(quo_new[CENTER_W-1:0]);
                end else begin
                    track_l_reg <= X_W'(quo_new[CENTER_W-1:0]);
                end
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pend_col_reg <= col_reg;
            pend_pix_reg <= s_item.pixel_value;
        end
        rd_x_reg <= idx_reg;
        // First-maximum compare, one column per cycle
        if (rd_v_reg) begin
            if (rd_x_reg < X_W'(IMG_WIDTH / 2)) begin
                if (rd_x_reg == '0 || col_rdata > bval_l_reg) begin
                    best_l_reg <= rd_x_reg;
                    bval_l_reg <= col_rdata;
                end
            end else if (rd_x_reg == X_W'(IMG_WIDTH / 2) || col_rdata > bval_r_reg) begin
                best_r_reg <= rd_x_reg;
                bval_r_reg <= col_rdata;
            end
        end
        // Window stepping
        if (cmd.win_init) begin
            win_reg  <= '0;
            base_reg <= PIX_W'(BASE_FIRST);
            side_reg <= 1'b0;
        end else if (cmd.next_win) begin
            win_reg  <= win_reg + 1'b1;
            base_reg <= base_reg - PIX_W'(BASE_STEP);
            side_reg <= 1'b0;
        end else if (cmd.side_next) begin
            side_reg <= 1'b1;
        end
        // Box raster walk
        if (cmd.box_init) begin
            xlo_reg      <= xlo_c;
            xhi_reg      <= xhi_c;
            x_reg        <= xlo_c;
            row_reg      <= '0;
            row_addr_reg <= base_reg;
        end else if (cmd.box_step) begin
            if (x_last) begin
                x_reg        <= xlo_reg;
                row_reg      <= row_reg + 1'b1;
                row_addr_reg <= row_addr_reg + PIX_W'(IMG_WIDTH);
            end else begin
                x_reg <= x_reg + 1'b1;
            end
        end
        bx_reg <= X_W'(x_reg);
        // Hit count and x sum
        if (cmd.box_init) begin
            if (side_reg) begin
                cnt_r_reg <= '0;
                sum_r_reg <= '0;
            end else begin
                cnt_l_reg <= '0;
                sum_l_reg <= '0;
            end
        end else if (bv_reg && map_rdata) begin
            if (side_reg) begin
                cnt_r_reg <= cnt_r_reg + 1'b1;
                sum_r_reg <= sum_r_reg + SUM_W'(bx_reg);
            end else begin
                cnt_l_reg <= cnt_l_reg + 1'b1;
                sum_l_reg <= sum_l_reg + SUM_W'(bx_reg);
            end
        end
        // Divider datapath
        if (cmd.div_start_l || cmd.div_start_r) begin
            div_side_reg <= cmd.div_start_r;
            div_cnt_reg  <= DCNT_W'(SUM_W);
            div_rem_reg  <= '0;
            div_quo_reg  <= cmd.div_start_r ? sum_r_reg : sum_l_reg;
            div_d_reg    <= cmd.div_start_r ? cnt_r_reg : cnt_l_reg;
        end else if (div_run_reg) begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
            div_rem_reg <= div_bit ? div_trial - {1'b0, div_d_reg} : div_trial;
            div_quo_reg <= quo_new;
        end
        // Result item
        if (cmd.emit) begin
            m_item_reg.window_number <= WNUM_W'(win_reg);
            m_item_reg.left_center   <= CENTER_W'(track_l_reg);
            m_item_reg.right_center  <= CENTER_W'(track_r_reg);
            m_item_reg.left_hits     <= (32'(cnt_l_reg) > 32'd65535) ? '1 : HITS_W'(cnt_l_reg);
            m_item_reg.right_hits    <= (32'(cnt_r_reg) > 32'd65535) ? '1 : HITS_W'(cnt_r_reg);
            m_item_reg.last_window   <= (win_reg == WIN_W'(NUM_WINDOWS - 1));
        end
    end

    // Status to the controller
    always_comb begin
        status.idx_last   = (idx_reg == X_W'(IMG_WIDTH - 1));
        status.box_empty  = (xlo_c >= xhi_c);
        status.box_last   = x_last && row_last;
        status.side_right = side_reg;
        status.recenter_l = (32'(cnt_l_reg) > 32'(min_pixels)) && (cnt_l_reg != '0);
        status.recenter_r = (32'(cnt_r_reg) > 32'(min_pixels)) && (cnt_r_reg != '0);
        status.div_done   = div_run_reg && (div_cnt_reg == DCNT_W'(1));
        status.win_last   = (win_reg == WIN_W'(NUM_WINDOWS - 1));
        status.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### hdl/sliding_window_lane_search.sv
// Sequence: pixel items are loaded; a frame_end item is followed by a
// column scan, then per window the two boxes are walked one map bit per
// cycle, the result is emitted when the output is free, and a divide
// runs per recentered side before the step to the next window.
// Throughput: one pixel per cycle while loading. Reset: synchronous, active
// low; then a clearing pass over the column sums with no item accepted.
module sliding_window_lane_search #(
    parameter int IMG_WIDTH   = swls_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT  = swls_pkg::IMG_HEIGHT_DEF,
    parameter int NUM_WINDOWS = swls_pkg::NUM_WINDOWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  swls_pkg::in_item_t                s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output swls_pkg::out_item_t               m_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swls_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [swls_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [swls_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import swls_pkg::*;

    `include "sliding_window_lane_search_defines.svh"

    logic [HW_W-1:0]  half_width_reg;
    logic [THR_W-1:0] min_pixels_reg;
    swls_cmd_t        cmd;
    swls_status_t     status;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg <= HW_RESET;
            min_pixels_reg <= THR_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_HALF_WIDTH: half_width_reg <= pwdata[HW_W-1:0];
                REG_MIN_PIXELS: min_pixels_reg <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        unique case (paddr[2])
            REG_HALF_WIDTH: prdata = APB_DATA_W'(half_width_reg);
            REG_MIN_PIXELS: prdata = APB_DATA_W'(min_pixels_reg);
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    swls_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_frame_end (s_item.frame_end),
        .status      (status),
        .cmd         (cmd),
        .s_ready     (s_ready)
    );

    swls_datapath #(
        .IMG_WIDTH   (IMG_WIDTH),
        .IMG_HEIGHT  (IMG_HEIGHT),
        .NUM_WINDOWS (NUM_WINDOWS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_item     (s_item),
        .half_width (half_width_reg),
        .min_pixels (min_pixels_reg),
        .m_ready    (m_ready),
        .status     (status),
        .m_valid    (m_valid),
        .m_item     (m_item)
    );

    // Frame end stops input until the search is done
    `SWLS_ASSERT_NXT(a_fend_blocks, aclk, aresetn, s_valid && s_ready && s_item.frame_end, !s_ready)
    // More windows pending keeps input blocked
    `SWLS_ASSERT_NXT(a_search_busy, aclk, aresetn, m_valid && m_ready && !m_item.last_window, !s_ready)
    // Divider never runs while input is accepted
    `SWLS_ASSERT_IMP(a_no_div_load, aclk, aresetn, s_ready, !status.div_done)

endmodule

### tb/sv/sliding_window_lane_search_tb.sv
// Self-checking testbench for the sliding window lane search block.
// Depends on swls_pkg and the sliding_window_lane_search RTL only.
`timescale 1ns / 1ps

// Tracks frame state, predicts the per-window search results and checks them
class lane_scoreboard;
    localparam int W      = swls_pkg::IMG_WIDTH_DEF;
    localparam int H      = swls_pkg::IMG_HEIGHT_DEF;
    localparam int NW     = swls_pkg::NUM_WINDOWS_DEF;
    localparam int TOTAL  = W * H;
    localparam int SUMMAX = (1 << swls_pkg::COLSUM_W) - 1;

    bit                   lane_map [TOTAL];
    int unsigned          col_sum [W];
    int unsigned          pix_pos;
    int                   half_w;
    int unsigned          recenter_min;
    swls_pkg::out_item_t  window_q [$];
    int                   errors;
    int                   windows_seen;
    int                   frames_seen;

    function new();
        pix_pos      = 0;
        half_w       = swls_pkg::HW_RESET;
        recenter_min = swls_pkg::THR_RESET;
        errors       = 0;
        windows_seen = 0;
        frames_seen  = 0;
        foreach (col_sum[i]) col_sum[i] = 0;
    endfunction

    task report(string what, int unsigned got, int unsigned exp_v);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d", what, got, exp_v);
    endtask

    // First column with the largest sum in [lo, hi)
    function int unsigned peak_col(int lo, int hi);
        int best;
        best = lo;
        for (int x = lo + 1; x < hi; x++)
            if (col_sum[x] > col_sum[best]) best = x;
        return best;
    endfunction

    // Count and x-sum of lane pixels in one box of a row band
    function void box_hits(int center, int ylo, int yhi,
                           output int unsigned n, output int unsigned xs);
        int xlo, xhi;
        xlo = center - half_w;
        xhi = center + half_w;
        n   = 0;
        xs  = 0;
        if (xlo < 0) xlo = 0;
        if (xhi > W) xhi = W;
        for (int y = ylo; y < yhi; y++)
            for (int x = xlo; x < xhi; x++)
                if (lane_map[y * W + x]) begin
                    n++;
                    xs += x;
                end
    endfunction

    // Accepted pixel: update map and sums; on frame end run the search
    function void note_pixel(swls_pkg::in_item_t it);
        int unsigned row, col, s, ln, ls, rn, rs;
        int unsigned lt, rt;
        int band;
        swls_pkg::out_item_t r;
        row = pix_pos / W;
        col = pix_pos % W;
        band = H / NW;
        lane_map[pix_pos] = (it.pixel_value != 0);
        if (row >= H / 2) begin
            s = col_sum[col] + it.pixel_value;
            col_sum[col] = (s > SUMMAX) ? SUMMAX : s;
        end
        pix_pos = (pix_pos + 1) % TOTAL;
        if (!it.frame_end) return;

        frames_seen++;
        lt = peak_col(0, W / 2);
        rt = peak_col(W / 2, W);
        for (int w = 0; w < NW; w++) begin
            box_hits(lt, H - (w + 1) * band, H - w * band, ln, ls);
            box_hits(rt, H - (w + 1) * band, H - w * band, rn, rs);
            r.window_number = 3'(w);
            r.left_center   = 9'(lt);
            r.right_center  = 9'(rt);
            r.left_hits     = (ln > 65535) ? 16'hFFFF : 16'(ln);
            r.right_hits    = (rn > 65535) ? 16'hFFFF : 16'(rn);
            r.last_window   = (w == NW - 1);
            window_q = {window_q, r};
            if (ln > recenter_min && ln != 0) lt = (ls / ln) & 9'h1FF;
            if (rn > recenter_min && rn != 0) rt = (rs / rn) & 9'h1FF;
        end
        foreach (col_sum[i]) col_sum[i] = 0;
        pix_pos = 0;
    endfunction

    task check_window(swls_pkg::out_item_t got);
        swls_pkg::out_item_t e;
        windows_seen++;
        if (window_q.size() == 0) begin
            report("unexpected window item", got.window_number, 0);
            return;
        end
        e = window_q.pop_front();
        if (got.window_number != e.window_number)
            report("window_number", got.window_number, e.window_number);
        if (got.left_center != e.left_center)
            report("left_center", got.left_center, e.left_center);
        if (got.right_center != e.right_center)
            report("right_center", got.right_center, e.right_center);
        if (got.left_hits != e.left_hits)
            report("left_hits", got.left_hits, e.left_hits);
        if (got.right_hits != e.right_hits)
            report("right_hits", got.right_hits, e.right_hits);
        if (got.last_window != e.last_window)
            report("last_window", got.last_window, e.last_window);
    endtask
endclass

module sliding_window_lane_search_tb;
    import swls_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;

    lane_scoreboard sb;
    bit          no_idle;
    int          rx_hold_len;
    int          random_items;

    sliding_window_lane_search u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Limit on the whole run
    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Handshake monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_window(m_item);
            if (s_valid && s_ready) sb.note_pixel(s_item);
        end
    end

    // Result side: random stalls, forced long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_len > 0) begin
                m_ready = 1'b0;
                repeat (rx_hold_len - 1) @(negedge aclk);
                rx_hold_len = 0;
            end else begin
                m_ready = no_idle || ($urandom_range(0, 99) >= 14);
            end
        end
    end

    task automatic write_reg(input logic idx, input int unsigned val);
        logic [APB_DATA_W-1:0] mask;
        mask = (idx == REG_HALF_WIDTH) ? (32'h1 << HW_W) - 1 : (32'h1 << THR_W) - 1;
        @(negedge aclk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        pwrite = 1'b0; penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if ((prdata & mask) != (val & mask)) sb.report("register readback", prdata, val);
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0;
        if (idx == REG_HALF_WIDTH) sb.half_w = val & mask;
        else sb.recenter_min = val & mask;
    endtask

    // Wait for all windows, then let the block finish its last divide
    task automatic drain();
        while (sb.window_q.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    // Offer one pixel item; called at a falling edge, returns at one
    task automatic send_pixel(input logic [7:0] v, input logic fe);
        if (!no_idle && $urandom_range(0, 99) < 14) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_item.pixel_value = v;
        s_item.frame_end   = fe;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Lane-like content: two drifting lines plus sparse noise
    function automatic logic [7:0] lane_pixel(int i, int ll, int rl);
        int row, col, cl, cr;
        row = i / 512;
        col = i % 512;
        cl = ll + (row % 97) / 8;
        cr = rl - (row % 61) / 6;
        if ((col >= cl - 3 && col <= cl + 3) || (col >= cr - 3 && col <= cr + 3)) begin
            if ($urandom_range(0, 9) < 7) return $urandom_range(0, 3) == 0 ? 8'hFF
                                                : $urandom_range(1, 255);
            return 8'h00;
        end
        if ($urandom_range(0, 99) < 3) return $urandom_range(1, 255);
        return 8'h00;
    endfunction

    task automatic send_frame(input int len, input int ll, input int rl);
        for (int i = 0; i < len; i++)
            send_pixel(lane_pixel(i, ll, rl), i == len - 1);
        s_valid = 1'b0;
    endtask

    initial begin
        int len;
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        no_idle = 1'b0;
        rx_hold_len = 0;
        random_items = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Narrow boxes keep the full-frame search short
        write_reg(REG_HALF_WIDTH, 6);
        write_reg(REG_MIN_PIXELS, 20);

        // Full frame first, so every map entry gets written
        for (int i = 0; i < 262144; i++) begin
            no_idle = (i >= 100000 && i < 150000);
            if (i == 0) send_pixel(8'hFF, 1'b0);
            else if (i == 1) send_pixel(8'h00, 1'b0);
            else send_pixel(lane_pixel(i, 120, 400), i == 262143);
        end
        no_idle = 1'b0;

        // Long hold-off on results while more items are offered
        rx_hold_len = 3000;
        send_pixel(8'hFF, 1'b1);          // one-pixel frame
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h01, 1'b1);
        s_valid = 1'b0;
        drain();

        // Zero box width, zero threshold
        write_reg(REG_HALF_WIDTH, 0);
        write_reg(REG_MIN_PIXELS, 0);
        for (int f = 0; f < 3; f++) send_frame($urandom_range(1, 30), 100, 380);
        drain();

        // Widest box, threshold above any possible hit count
        write_reg(REG_HALF_WIDTH, 512);
        write_reg(REG_MIN_PIXELS, 262144);
        no_idle = 1'b1;
        send_frame(5, 100, 380);
        drain();
        no_idle = 1'b0;

        // Medium frame reaching the bottom half so the start centers move
        write_reg(REG_HALF_WIDTH, 3);
        write_reg(REG_MIN_PIXELS, 2);
        send_frame(133072, $urandom_range(10, 240), $urandom_range(270, 500));
        drain();

        // Random short frames over varied settings
        while (random_items < 360) begin
            write_reg(REG_HALF_WIDTH, $urandom_range(1, 4));
            case ($urandom_range(0, 3))
                0: write_reg(REG_MIN_PIXELS, 0);
                1: write_reg(REG_MIN_PIXELS, 1);
                2: write_reg(REG_MIN_PIXELS, $urandom_range(0, 40));
                default: write_reg(REG_MIN_PIXELS, 262144);
            endcase
            for (int f = 0; f < 2; f++) begin
                len = $urandom_range(1, 50);
                send_frame(len, $urandom_range(0, 255), $urandom_range(256, 511));
                random_items += len;
            end
            drain();
        end

        $display("Covered %0d frames, %0d window results, incl. full, one-pixel,",
                 sb.frames_seen, sb.windows_seen);
        $display("zero and widest box settings, with stalls on both sides.");
        if (sb.errors == 0 && sb.window_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
